// ===== rtl/tbmc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbmc_pkg
// Shared types, widths and codes for the tile map box mover.
// ----------------------------------------------------------------------------
package tbmc_pkg;

  // Geometry
  localparam int COORD_W    = 16;                 // pixel coordinates
  localparam int PX_W       = 14;                 // map size in pixels
  localparam int TCNT_W     = 11;                 // map size in tiles
  localparam int TILE_SHIFT = 3;                  // 8-pixel tiles
  localparam int TILE_W     = PX_W - TILE_SHIFT;  // tile coordinate inside the map

  // Stores
  localparam int MAP_TILES  = 8192;
  localparam int MAP_AW     = $clog2(MAP_TILES);
  localparam int FLAG_DEPTH = 256;
  localparam int FLAG_AW    = $clog2(FLAG_DEPTH);

  // Stream widths
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 40;
  localparam int KIND_W     = 2;
  localparam int WADDR_W    = 13;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_MOVE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MAP  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FLAG = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH_PX    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT_PX   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH_TILES = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT_TILES = 2'd3;

  localparam logic [PX_W-1:0]   RST_WIDTH_PX    = 14'd256;
  localparam logic [PX_W-1:0]   RST_HEIGHT_PX   = 14'd256;
  localparam logic [TCNT_W-1:0] RST_WIDTH_TILES = 11'd32;
  localparam logic [TCNT_W-1:0] RST_HEIGHT_TILES = 11'd32;

  typedef struct packed {
    logic [PX_W-1:0]   width_px;
    logic [PX_W-1:0]   height_px;
    logic [TCNT_W-1:0] width_tiles;
    logic [TCNT_W-1:0] height_tiles;
  } cfg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] box_x;
    logic signed [COORD_W-1:0] box_y;
    logic [7:0]                box_width;
    logic [7:0]                box_height;
    logic [7:0]                group_mask;
    logic [7:0]                group_mask_down;
    logic signed [7:0]         step_x;
    logic signed [7:0]         step_y;
  } move_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] new_x;
    logic signed [COORD_W-1:0] new_y;
    logic [7:0]                hit_tile;
  } result_t;

  typedef struct packed {
    logic              en;
    logic [MAP_AW-1:0] addr;
  } map_rd_t;

  typedef struct packed {
    logic               en;
    logic [FLAG_AW-1:0] addr;
  } flag_rd_t;

endpackage

// ===== rtl/tbmc_tile_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbmc_tile_ram
// Tile map store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tbmc_tile_ram (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [tbmc_pkg::MAP_AW-1:0] wr_addr,
  input  logic [7:0]             wr_data,
  input  tbmc_pkg::map_rd_t      rd,
  output logic [7:0]             rd_data
);
  import tbmc_pkg::*;

  logic [7:0] mem [MAP_TILES];

  // Write tile numbers
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

// ===== rtl/tbmc_flag_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbmc_flag_ram
// Collision flag table: registered read, per-entry valid bits so that the
// table reads as zero after reset until an entry is written.
// ----------------------------------------------------------------------------
module tbmc_flag_ram (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    wr_en,
  input  logic [tbmc_pkg::FLAG_AW-1:0] wr_addr,
  input  logic [7:0]              wr_data,
  input  tbmc_pkg::flag_rd_t      rd,
  output logic [7:0]              rd_data
);
  import tbmc_pkg::*;

  logic [7:0]            mem [FLAG_DEPTH];
  logic [FLAG_DEPTH-1:0] valid;
  logic [7:0]            data_q;
  logic                  valid_q;

  // Track written entries
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // Store flag bytes
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read of the data and its valid bit
  always_ff @(posedge clk) begin
    if (rd.en) begin
      data_q  <= mem[rd.addr];
      valid_q <= valid[rd.addr];
    end
  end

  assign rd_data = valid_q ? data_q : 8'd0;

endmodule

// ===== rtl/tbmc_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbmc_scan
// Move sequencer: resolves the X axis then the Y axis, scanning the tiles of
// the destination column or row through the map and flag memories.
// ----------------------------------------------------------------------------
module tbmc_scan (
  input  logic                 clk,
  input  logic                 rst,
  input  tbmc_pkg::cfg_t       cfg,
  input  logic                 start,
  input  tbmc_pkg::move_t      move,
  output logic                 busy,
  output tbmc_pkg::map_rd_t    map_rd,
  input  logic [7:0]           map_rdata,
  output tbmc_pkg::flag_rd_t   flag_rd,
  input  logic [7:0]           flag_rdata,
  output logic                 res_valid,
  input  logic                 res_ready,
  output tbmc_pkg::result_t    res
);
  import tbmc_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LEAD  = 3'd1;
  localparam logic [2:0] ST_DEST  = 3'd2;
  localparam logic [2:0] ST_INDEX = 3'd3;
  localparam logic [2:0] ST_MAP   = 3'd4;
  localparam logic [2:0] ST_FLAG  = 3'd5;
  localparam logic [2:0] ST_CHECK = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  // Clamp a coordinate of the other extent to a tile inside the map
  function automatic logic [TILE_W-1:0] clamp_tile(input logic [COORD_W-1:0] c,
                                                   input logic [PX_W-1:0]    lim,
                                                   input logic [TCNT_W-1:0]  tiles);
    logic [TILE_W-1:0] r;
    if (c >= COORD_W'(lim)) begin
      if (c[COORD_W-1]) begin
        r = '0;
      end else if (tiles != '0) begin
        r = TILE_W'(tiles - TCNT_W'(1));
      end else begin
        r = '0;
      end
    end else begin
      r = c[PX_W-1:TILE_SHIFT];
    end
    return r;
  endfunction

  logic [2:0]          state;
  logic                axis;       // 0: X, 1: Y
  move_t               mv;
  logic [COORD_W-1:0]  pos_x, pos_y;
  logic [7:0]          hit;
  logic [COORD_W-1:0]  lead_q, dest_q, oend_q, sum_q;
  logic [TILE_W-1:0]   t_q, o_q, o1_q;
  logic [MAP_AW-1:0]   idx;
  logic [7:0]          tile_q;

  // Axis operand selection
  logic [COORD_W-1:0]  pos, opos;
  logic [7:0]          size, osize, mask;
  logic signed [7:0]   step;
  logic [PX_W-1:0]     lim, olim;
  logic [TCNT_W-1:0]   otiles;

  always_comb begin
    pos    = axis ? pos_y : pos_x;
    opos   = axis ? pos_x : pos_y;
    size   = axis ? mv.box_height : mv.box_width;
    osize  = axis ? mv.box_width : mv.box_height;
    step   = axis ? mv.step_y : mv.step_x;
    lim    = axis ? cfg.height_px : cfg.width_px;
    olim   = axis ? cfg.width_px : cfg.height_px;
    otiles = axis ? cfg.width_tiles : cfg.height_tiles;
    mask   = (axis && !mv.step_y[7]) ? mv.group_mask_down : mv.group_mask;
  end

  // Leading edge and destination
  logic [COORD_W-1:0] step_ext, lead, dest, oend, sum;
  always_comb begin
    step_ext = {{(COORD_W-8){step[7]}}, step};
    lead     = step[7] ? pos : pos + COORD_W'(8'(size - 8'd1));
    dest     = lead + step_ext;
    oend     = opos + COORD_W'(osize) - COORD_W'(1);
    sum      = pos + step_ext;
  end

  // Column or row bounds
  logic [TILE_W-1:0] o0, o1;
  always_comb begin
    o0 = clamp_tile(opos, olim, otiles);
    o1 = clamp_tile(oend_q, olim, otiles);
  end

  // Start index and stride in the map
  logic [2*TCNT_W-1:0] prod;
  logic [MAP_AW-1:0]   idx_start, stride;
  always_comb begin
    prod      = (axis ? TCNT_W'(t_q) : TCNT_W'(o_q)) * cfg.width_tiles;
    idx_start = MAP_AW'(prod) + MAP_AW'(axis ? o_q : t_q);
    stride    = axis ? MAP_AW'(1) : MAP_AW'(cfg.width_tiles);
  end

  // Flush position after a hit
  logic [COORD_W-1:0] snap_base, snap;
  always_comb begin
    snap_base = COORD_W'(t_q) << TILE_SHIFT;
    snap = step[7] ? snap_base + (COORD_W'(1) << TILE_SHIFT)
                   : snap_base - COORD_W'(size);
  end

  // Axis outcome
  logic               ax_done, ax_hit, scan_go;
  logic [COORD_W-1:0] ax_val;
  always_comb begin
    ax_done = 1'b0;
    ax_hit  = 1'b0;
    scan_go = 1'b0;
    ax_val  = sum_q;
    case (state)
      ST_DEST: begin
        if (step == '0) begin
          ax_done = 1'b1;
          ax_val  = pos;
        end else if ((lead_q[COORD_W-1:TILE_SHIFT] == dest_q[COORD_W-1:TILE_SHIFT]) ||
                     (dest_q >= COORD_W'(lim)) || (o0 > o1)) begin
          ax_done = 1'b1;
        end else begin
          scan_go = 1'b1;
        end
      end
      ST_CHECK: begin
        if ((flag_rdata & mask) != '0) begin
          ax_done = 1'b1;
          ax_hit  = 1'b1;
          ax_val  = snap;
        end else if (o_q == o1_q) begin
          ax_done = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      axis  <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_LEAD;
            axis  <= 1'b0;
          end
        end
        ST_LEAD:  state <= ST_DEST;
        ST_INDEX: state <= ST_MAP;
        ST_MAP:   state <= ST_FLAG;
        ST_FLAG:  state <= ST_CHECK;
        ST_DONE: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          // ST_DEST and ST_CHECK
          if (ax_done) begin
            if (axis) begin
              state <= ST_DONE;
            end else begin
              state <= ST_LEAD;
              axis  <= 1'b1;
            end
          end else if (scan_go) begin
            state <= ST_INDEX;
          end else begin
            state <= ST_MAP;
          end
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          mv    <= move;
          pos_x <= move.box_x;
          pos_y <= move.box_y;
          hit   <= 8'd0;
        end
      end
      ST_LEAD: begin
        lead_q <= lead;
        dest_q <= dest;
        oend_q <= oend;
        sum_q  <= sum;
      end
      ST_DEST: begin
        t_q  <= dest_q[PX_W-1:TILE_SHIFT];
        o_q  <= o0;
        o1_q <= o1;
      end
      ST_INDEX: idx <= idx_start;
      ST_FLAG:  tile_q <= map_rdata;
      ST_CHECK: begin
        if (!ax_done) begin
          o_q <= o_q + TILE_W'(1);
          idx <= idx + stride;
        end
      end
      default: begin
      end
    endcase
    // Commit the finished axis
    if (ax_done) begin
      if (axis) begin
        pos_y <= ax_val;
      end else begin
        pos_x <= ax_val;
      end
      if (ax_hit) begin
        hit <= tile_q;
      end
    end
  end

  assign busy           = (state != ST_IDLE);
  assign map_rd.en      = (state == ST_MAP);
  assign map_rd.addr    = idx;
  assign flag_rd.en     = (state == ST_FLAG);
  assign flag_rd.addr   = map_rdata;
  assign res_valid      = (state == ST_DONE);
  assign res.new_x      = pos_x;
  assign res.new_y      = pos_y;
  assign res.hit_tile   = hit;

endmodule

// ===== rtl/tilemap_box_move_collide.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilemap_box_move_collide
// Moves a collision box over a stored tile map, X first then Y, stopping
// flush at the first tile whose collision flags match the group mask.
// ----------------------------------------------------------------------------
// Sequencing: a write word is taken while idle; a move word steps through the
//   lead and destination states per axis, plus the index state and a map read,
//   flag read and check per scanned tile for an axis that scans a column or row,
//   then waits in the done state until the output register takes the result.
// Throughput: one item at a time; the input is held off while a move is in flight.
// Reset: config registers return to 256/256/32/32, the flag table reads zero.
// ----------------------------------------------------------------------------
module tilemap_box_move_collide (
  input  logic                                clk,
  input  logic                                rst,
  // box_x, box_y, box_width, box_height, group_mask, group_mask_down,
  // step_x, step_y, write_addr, write_data, zero fill
  input  logic [tbmc_pkg::IN_DATA_W-1:0]      s_tdata,
  input  logic [tbmc_pkg::KIND_W-1:0]         s_tuser,   // kind
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // new_x, new_y, hit_tile
  output logic [tbmc_pkg::OUT_DATA_W-1:0]     m_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tbmc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tbmc_pkg::PX_W-1:0]           cfg_data
);
  import tbmc_pkg::*;

  cfg_t     cfg;
  move_t    move;
  result_t  res;
  map_rd_t  map_rd;
  flag_rd_t flag_rd;
  logic [7:0]         map_rdata, flag_rdata;
  logic [WADDR_W-1:0] waddr;
  logic [7:0]         wdata;
  logic               in_fire, busy, res_valid, res_ready;
  logic               map_we, flag_we;

  // Unpack the input word
  always_comb begin
    move.box_x           = s_tdata[15:0];
    move.box_y           = s_tdata[31:16];
    move.box_width       = s_tdata[39:32];
    move.box_height      = s_tdata[47:40];
    move.group_mask      = s_tdata[55:48];
    move.group_mask_down = s_tdata[63:56];
    move.step_x          = s_tdata[71:64];
    move.step_y          = s_tdata[79:72];
    waddr                = s_tdata[92:80];
    wdata                = s_tdata[100:93];
  end

  assign s_tready = !busy;
  assign in_fire  = s_tvalid && s_tready;
  assign map_we   = in_fire && (s_tuser == KIND_MAP) && (32'(waddr) < MAP_TILES);
  assign flag_we  = in_fire && (s_tuser == KIND_FLAG) && (32'(waddr) < FLAG_DEPTH);

  // Configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width_px     <= RST_WIDTH_PX;
      cfg.height_px    <= RST_HEIGHT_PX;
      cfg.width_tiles  <= RST_WIDTH_TILES;
      cfg.height_tiles <= RST_HEIGHT_TILES;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAP_WIDTH_PX:     cfg.width_px     <= cfg_data;
        CFG_MAP_HEIGHT_PX:    cfg.height_px    <= cfg_data;
        CFG_MAP_WIDTH_TILES:  cfg.width_tiles  <= cfg_data[TCNT_W-1:0];
        CFG_MAP_HEIGHT_TILES: cfg.height_tiles <= cfg_data[TCNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  tbmc_tile_ram u_tile_ram (
    .clk     (clk),
    .wr_en   (map_we),
    .wr_addr (waddr[MAP_AW-1:0]),
    .wr_data (wdata),
    .rd      (map_rd),
    .rd_data (map_rdata)
  );

  tbmc_flag_ram u_flag_ram (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (flag_we),
    .wr_addr (waddr[FLAG_AW-1:0]),
    .wr_data (wdata),
    .rd      (flag_rd),
    .rd_data (flag_rdata)
  );

  tbmc_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .start      (in_fire && (s_tuser == KIND_MOVE)),
    .move       (move),
    .busy       (busy),
    .map_rd     (map_rd),
    .map_rdata  (map_rdata),
    .flag_rd    (flag_rd),
    .flag_rdata (flag_rdata),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // Output register: take a result when the slot is free or draining
  assign res_ready = !m_tvalid || m_tready;
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= {res.hit_tile, res.new_y, res.new_x};
    end
  end

endmodule

// ===== sim/tb_tilemap_box_move_collide.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tilemap_box_move_collide
// Self-checking bench for the tile map box mover. It keeps its own copy of the
// map, the flag table and the map geometry, and predicts every move result.
// Directed hits, clamps and ignored words come first. Map and geometry
// extremes, a long output stall and random traffic follow. Both stream sides
// idle at random.
// ----------------------------------------------------------------------------
module tb_tilemap_box_move_collide;
  import tbmc_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int ITEM_TARGET    = 1150;
  localparam int PRINT_LIMIT    = 100;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic [IN_DATA_W-1:0]     s_tdata = '0;
  logic [KIND_W-1:0]        s_tuser = '0;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [OUT_DATA_W-1:0]    m_tdata;
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [PX_W-1:0]          cfg_data = '0;

  tilemap_box_move_collide i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the block's state
  int unsigned map_w_px    = 32'(RST_WIDTH_PX);
  int unsigned map_h_px    = 32'(RST_HEIGHT_PX);
  int unsigned map_w_tiles = 32'(RST_WIDTH_TILES);
  int unsigned map_h_tiles = 32'(RST_HEIGHT_TILES);
  logic [7:0]  tile_store [MAP_TILES];
  bit          tile_known [MAP_TILES];
  logic [7:0]  flag_store [FLAG_DEPTH];

  result_t     expected_moves [$];
  int          errors = 0;
  int          items_sent = 0;
  int          idle_cycles = 0;
  bit          offering = 1'b0;  // s_tvalid is held high for the current word
  bit          steady = 1'b0;    // no idling on either side
  int          hold_off = 0;     // long output stall request

  initial begin
    foreach (flag_store[i]) flag_store[i] = '0;
  end

  // Clock and reset
  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic int wrap16(int v);
    logic signed [15:0] t;
    t = v[15:0];
    return int'(t);
  endfunction

  function automatic int clamp_tile(int c, int unsigned lim_px, int unsigned lim_tiles);
    if ((c & 32'hFFFF) >= lim_px) begin
      if (c < 0) return 0;
      return (lim_tiles != 0) ? int'(lim_tiles) - 1 : 0;
    end
    return c >>> TILE_SHIFT;
  endfunction

  // Move one axis; stop at the first unwritten map entry and report its index
  function automatic int axis_move(int pos, int size, int step, int opos, int osize,
                                   bit horiz, logic [7:0] mask,
                                   inout logic [7:0] hit, inout int missing);
    int unsigned lim, olim, otiles, idx;
    int lead, dest, t, o, o0, o1;
    logic [7:0] tile;
    lim    = horiz ? map_w_px : map_h_px;
    olim   = horiz ? map_h_px : map_w_px;
    otiles = horiz ? map_h_tiles : map_w_tiles;
    if (step == 0 || missing >= 0) return pos;
    lead = (step > 0) ? wrap16(pos + ((size - 1) & 255)) : pos;
    dest = wrap16(lead + step);
    if ((lead >>> TILE_SHIFT) == (dest >>> TILE_SHIFT)) return wrap16(pos + step);
    if ((dest & 32'hFFFF) >= lim) return wrap16(pos + step);
    t  = dest >>> TILE_SHIFT;
    o0 = clamp_tile(opos, olim, otiles);
    o1 = clamp_tile(wrap16(opos + osize - 1), olim, otiles);
    for (o = o0; o <= o1; o++) begin
      idx = horiz ? map_w_tiles * o + t : map_w_tiles * t + o;
      idx = idx % MAP_TILES;
      if (!tile_known[idx]) begin
        missing = idx;
        return pos;
      end
      tile = tile_store[idx];
      if ((flag_store[tile] & mask) != 0) begin
        hit = tile;
        if (step > 0) return wrap16((t << TILE_SHIFT) - size);
        return wrap16((t + 1) << TILE_SHIFT);
      end
    end
    return wrap16(pos + step);
  endfunction

  function automatic result_t predict_move(move_t m, output int missing);
    int x, y;
    logic [7:0] hit;
    result_t r;
    hit = '0;
    missing = -1;
    x = axis_move(m.box_x, m.box_width, m.step_x, m.box_y, m.box_height, 1'b1,
                  m.group_mask, hit, missing);
    y = axis_move(m.box_y, m.box_height, m.step_y, x, m.box_width, 1'b0,
                  (m.step_y < 0) ? m.group_mask : m.group_mask_down, hit, missing);
    r.new_x    = x[15:0];
    r.new_y    = y[15:0];
    r.hit_tile = hit;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic move_t mk_move(int x, int y, int w, int h, int gm, int gmd,
                                    int sx, int sy);
    move_t m;
    m.box_x = x[15:0];
    m.box_y = y[15:0];
    m.box_width = w[7:0];
    m.box_height = h[7:0];
    m.group_mask = gm[7:0];
    m.group_mask_down = gmd[7:0];
    m.step_x = sx[7:0];
    m.step_y = sy[7:0];
    return m;
  endfunction

  function automatic move_t noise_fields();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(move_t)-1:0];
  endfunction

  // Mostly boxes near the map with small sizes, some fully random words
  function automatic move_t random_move();
    move_t m;
    int roll;
    m = noise_fields();
    roll = $urandom_range(0, 99);
    if (roll < 80) begin
      m.box_x = 16'($urandom_range(0, map_w_px + 32) - 16);
      m.box_y = 16'($urandom_range(0, map_h_px + 32) - 16);
      m.box_width  = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(1, 24))
                                                 : 8'($urandom_range(1, 255));
      m.box_height = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(1, 24))
                                                 : 8'($urandom_range(1, 255));
      if ($urandom_range(0, 49) == 0) m.box_width = '0;
      if ($urandom_range(0, 49) == 0) m.box_height = '0;
      if ($urandom_range(0, 6) == 0) m.step_x = '0;
      if ($urandom_range(0, 6) == 0) m.step_y = '0;
    end
    return m;
  endfunction

  // Drive one word, hold it until accepted, then update the shadow state
  task automatic send_word(logic [KIND_W-1:0] kind, move_t m, logic [WADDR_W-1:0] waddr,
                           logic [7:0] wdata);
    int gap;
    int missing;
    gap = steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      if (offering) s_tvalid <= 1'b0;
      offering = 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tuser  <= kind;
    s_tdata  <= {3'b000, wdata, waddr, m.step_y, m.step_x, m.group_mask_down,
                 m.group_mask, m.box_height, m.box_width, m.box_y, m.box_x};
    s_tvalid <= 1'b1;
    offering = 1'b1;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    case (kind)
      KIND_MAP: begin
        tile_store[waddr] = wdata;
        tile_known[waddr] = 1'b1;
      end
      KIND_FLAG: if (waddr < FLAG_DEPTH) flag_store[waddr[FLAG_AW-1:0]] = wdata;
      KIND_MOVE: expected_moves.push_back(predict_move(m, missing));
      default: ;
    endcase
  endtask

  task automatic send_map(int addr, int data);
    send_word(KIND_MAP, noise_fields(), addr[WADDR_W-1:0], data[7:0]);
  endtask

  task automatic send_flags(int addr, int data);
    send_word(KIND_FLAG, noise_fields(), addr[WADDR_W-1:0], data[7:0]);
  endtask

  // Fill every map entry the move would read that was never written, then send it
  task automatic send_move(move_t m);
    int missing;
    result_t r;
    forever begin
      r = predict_move(m, missing);
      if (missing < 0) break;
      send_map(missing, $urandom_range(0, 255));
    end
    send_word(KIND_MOVE, m, WADDR_W'($urandom), 8'($urandom));
  endtask

  task automatic release_stream();
    if (offering) s_tvalid <= 1'b0;
    offering = 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    release_stream();
    while (expected_moves.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Program the map geometry while the block is idle
  task automatic set_map(int w_px, int h_px, int w_tiles, int h_tiles);
    logic [CFG_IDX_W-1:0] idx [4];
    int value [4];
    idx   = '{CFG_MAP_WIDTH_PX, CFG_MAP_HEIGHT_PX, CFG_MAP_WIDTH_TILES, CFG_MAP_HEIGHT_TILES};
    value = '{w_px, h_px, w_tiles, h_tiles};
    wait_drained();
    for (int i = 0; i < 4; i++) begin
      cfg_index <= idx[i];
      cfg_data  <= value[i][PX_W-1:0];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      case (idx[i])
        CFG_MAP_WIDTH_PX:     map_w_px    = value[i] & 16'h3FFF;
        CFG_MAP_HEIGHT_PX:    map_h_px    = value[i] & 16'h3FFF;
        CFG_MAP_WIDTH_TILES:  map_w_tiles = value[i] & 16'h7FF;
        default:              map_h_tiles = value[i] & 16'h7FF;
      endcase
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_items(int count);
    int stop_at;
    int roll;
    int area;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      roll = $urandom_range(0, 99);
      area = map_w_tiles * map_h_tiles;
      if (roll < 70) begin
        send_move(random_move());
      end else if (roll < 84) begin
        if ($urandom_range(0, 9) < 7 && area > 0)
          send_map($urandom_range(0, area - 1) % MAP_TILES, $urandom_range(0, 255));
        else
          send_map($urandom_range(0, MAP_TILES - 1), $urandom_range(0, 255));
      end else if (roll < 95) begin
        send_flags(($urandom_range(0, 6) != 0) ? $urandom_range(0, 255)
                                               : $urandom_range(0, MAP_TILES - 1),
                   ($urandom_range(0, 4) < 2) ? 0 : $urandom_range(0, 255));
      end else begin
        send_word(KIND_UNUSED, noise_fields(), WADDR_W'($urandom), 8'($urandom));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Flag table reads zero after reset: nothing stops the box
  task automatic test_flag_reset();
    send_move(mk_move(16, 16, 8, 8, 8'hFF, 8'hFF, 16, 16));
    send_move(mk_move(40, 40, 30, 30, 8'hFF, 8'hFF, -20, -20));
  endtask

  // Hits in all four directions, clamps, and the corner cases of the geometry
  task automatic test_directed_moves();
    send_flags(5, 8'h01);
    send_flags(9, 8'h80);
    send_map(2 * 32 + 4, 5);
    send_map(2 * 32 + 0, 5);
    send_map(4 * 32 + 2, 9);
    send_map(4 * 32 + 3, 9);
    send_map(0 * 32 + 2, 5);
    send_move(mk_move(16, 16, 8, 8, 8'h01, 8'h00, 16, 0));     // right hit
    send_move(mk_move(12, 16, 8, 8, 8'h01, 8'h00, -8, 0));     // left hit
    send_move(mk_move(16, 16, 8, 8, 8'h01, 8'h80, 0, 16));     // down hit
    send_move(mk_move(16, 16, 8, 8, 8'h80, 8'h00, 0, 16));     // down ignores group mask
    send_move(mk_move(16, 12, 8, 8, 8'h01, 8'h00, 0, -8));     // up hit
    send_move(mk_move(16, 16, 8, 8, 8'h01, 8'h80, 16, 16));    // Y hit overrides X hit
    send_move(mk_move(17, 17, 4, 4, 8'hFF, 8'hFF, 1, -1));     // stays in its tile
    send_move(mk_move(250, 16, 8, 8, 8'hFF, 8'hFF, 20, 0));    // edge leaves the map
    send_move(mk_move(-32768, 32767, 255, 255, 8'hFF, 8'hFF, -128, 127));
    send_move(mk_move(32767, -32768, 1, 1, 8'hFF, 8'hFF, 127, -128));
    send_move(mk_move(16, -20, 8, 40, 8'h01, 8'h00, 16, 0));   // negative extent clamps
    send_move(mk_move(16, 300, 8, 8, 8'hFF, 8'hFF, 16, 0));    // extent past the map
    send_move(mk_move(16, 32760, 8, 20, 8'hFF, 8'hFF, 16, 0)); // wrapped extent
    send_move(mk_move(16, 16, 0, 0, 8'hFF, 8'hFF, 16, -16));   // zero box size
    send_move(mk_move(100, 100, 10, 10, 8'hFF, 8'hFF, 0, 0));  // no step
  endtask

  // Unused kind and out-of-range flag writes leave the state alone
  task automatic test_ignored_words();
    send_word(KIND_UNUSED, noise_fields(), 13'h1FFF, 8'hFF);
    send_flags(300, 8'hFF);            // would alias entry 44
    send_map(6 * 32 + 4, 44);
    send_move(mk_move(16, 48, 8, 8, 8'hFF, 8'hFF, 16, 0));
    send_map(MAP_TILES - 1, 8'hFF);
    send_flags(FLAG_DEPTH - 1, 8'hFF);
  endtask

  // Smallest, a large and a mismatched map geometry
  task automatic test_map_extremes();
    set_map(8, 8, 1, 1);
    random_items(80);
    set_map(8192, 8192, 1024, 1024);
    random_items(120);
    set_map(8192, 16, 4, 2);
    random_items(80);
  endtask

  // Stall the output long enough for the block to back up into its input
  task automatic test_backpressure();
    set_map(256, 256, 32, 32);
    steady = 1'b1;
    hold_off = 300;
    for (int i = 0; i < 30; i++) send_move(random_move());
    steady = 1'b0;
  endtask

  task automatic test_random_traffic();
    int px_w, px_h;
    int phase;
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      px_w = $urandom_range(8, 1024);
      px_h = $urandom_range(8, 1024);
      set_map(px_w, px_h, (px_w + 7) / 8, (px_h + 7) / 8);
      steady = (phase % 4 == 2);
      random_items((ITEM_TARGET - items_sent < 120) ? ITEM_TARGET - items_sent : 120);
      steady = 1'b0;
      phase++;
    end
  endtask

  initial begin
    @(negedge rst);
    @(posedge clk);
    test_flag_reset();
    test_directed_moves();
    test_ignored_words();
    test_map_extremes();
    test_backpressure();
    test_random_traffic();
    wait_drained();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Output side: random stalls, long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    int stall;
    forever begin
      if (hold_off > 0) begin
        stall = hold_off;
        hold_off = 0;
      end else begin
        stall = steady ? 0 : $urandom_range(0, 7);
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready) && hold_off == 0);
    end
  end

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string what, int got, int want);
    if (errors < PRINT_LIMIT)
      $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_moves.size() == 0) begin
        report_mismatch("result with no move pending", m_tdata[15:0], 0);
      end else begin
        want = expected_moves.pop_front();
        if (m_tdata[15:0] !== want.new_x)
          report_mismatch("new_x", $signed(m_tdata[15:0]), want.new_x);
        if (m_tdata[31:16] !== want.new_y)
          report_mismatch("new_y", $signed(m_tdata[31:16]), want.new_y);
        if (m_tdata[39:32] !== want.hit_tile)
          report_mismatch("hit_tile", m_tdata[39:32], want.hit_tile);
      end
    end
  end

  // Watchdog: end the run when nothing moves on any channel for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule

// ===== files.f =====
rtl/tbmc_pkg.sv
rtl/tbmc_tile_ram.sv
rtl/tbmc_flag_ram.sv
rtl/tbmc_scan.sv
rtl/tilemap_box_move_collide.sv
sim/tb_tilemap_box_move_collide.sv
